[src/urxf_pkg.sv]
// Shared types and constants for the UART receive ring with error tagging.
// No dependencies; imported by every module of the block.
package urxf_pkg;

    localparam int QUEUE_DEPTH_DEF = 1024;
    localparam int FILL_W          = 10;
    localparam int CNT_W           = 32;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam int LS_DR_BIT = 0;
    localparam int LS_PE_BIT = 2;
    localparam int LS_FE_BIT = 3;
    localparam int LS_BI_BIT = 4;

    localparam logic REG_IGNORE_BREAK = 1'b0;

    typedef struct packed {
        logic       opcode;
        logic [7:0] line_status;
        logic [7:0] rx_byte;
    } t_cmd;

    typedef struct packed {
        logic [7:0]        pop_byte;
        logic [2:0]        pop_flags;
        logic              pop_valid;
        logic [FILL_W-1:0] fill_count;
        logic              dropped_oldest;
        logic              discarded;
        logic [CNT_W-1:0]  overrun_total;
        logic [CNT_W-1:0]  parity_total;
        logic [CNT_W-1:0]  break_total;
        logic [CNT_W-1:0]  frame_total;
        logic [CNT_W-1:0]  received_total;
    } t_result;

    typedef struct packed {
        logic [2:0] flags;
        logic [7:0] data;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_stat;

    typedef struct packed {
        logic push;
        logic drop;
        logic parity;
        logic frame;
        logic brk;
    } t_stat_evt;

    typedef struct packed {
        logic [CNT_W-1:0] overrun;
        logic [CNT_W-1:0] parity;
        logic [CNT_W-1:0] brk;
        logic [CNT_W-1:0] frame;
        logic [CNT_W-1:0] received;
    } t_totals;

endpackage

[src/uart_rx_fifo_error_tagging_unit.sv]
// Top level of the UART receive ring with error tagging: command decode,
// configuration register and result register. Depends on urxf_pkg, urxf_ring, urxf_counters.
//
// One command (received byte or pop) is taken in every clock cycle; busy never rises.
// Each command yields one result, strobed on o_result_valid for exactly one cycle, the
// cycle after the command transfer; the result register is kept in step with the registered read
// port of the entry memory. The receiver cannot stall, so a result that is not taken in
// that cycle is lost. Totals and fill count in a result reflect the ring after that
// command. The entry memory needs no clearing pass after reset.
module uart_rx_fifo_error_tagging_unit #(
    parameter int QUEUE_DEPTH = urxf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  urxf_pkg::t_cmd                i_cmd,
    output logic                          o_result_valid,
    output urxf_pkg::t_result             o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [urxf_pkg::PADDR_W-1:0]  paddr,
    input  logic [urxf_pkg::PDATA_W-1:0]  pwdata,
    output logic [urxf_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import urxf_pkg::*;

    localparam int IW = $clog2(QUEUE_DEPTH);

    logic                 accept;
    logic                 is_byte;
    logic                 disc;
    logic                 r_ignore_break;
    logic                 r_valid;
    logic                 r_pop_valid;
    logic                 r_dropped;
    logic                 r_discarded;
    t_ring_cmd            ring_cmd;
    t_ring_stat           ring_stat;
    t_entry               wr_entry;
    t_entry               rd_entry;
    t_stat_evt            evt;
    t_totals              totals;
    logic [IW-1:0]        count;
    logic [IW+FILL_W-1:0] count_ext;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign accept = start && !busy;

    assign prdata = {{(PDATA_W-1){1'b0}}, r_ignore_break};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ignore_break <= 1'b0;
        end else if (psel && penable && pwrite && pready
                     && paddr[PADDR_W-1] == REG_IGNORE_BREAK) begin
            r_ignore_break <= pwdata[0];
        end
    end

    assign is_byte = accept && (i_cmd.opcode == OP_BYTE) && i_cmd.line_status[LS_DR_BIT];
    assign disc    = is_byte && r_ignore_break && i_cmd.line_status[LS_BI_BIT];

    assign ring_cmd.push = is_byte && !disc;
    assign ring_cmd.pop  = accept && (i_cmd.opcode == OP_POP) && !ring_stat.empty;

    assign wr_entry.data  = i_cmd.rx_byte;
    assign wr_entry.flags = {i_cmd.line_status[LS_BI_BIT],
                             i_cmd.line_status[LS_FE_BIT],
                             i_cmd.line_status[LS_PE_BIT]};

    assign evt.push   = ring_cmd.push;
    assign evt.drop   = ring_cmd.push && ring_stat.full;
    assign evt.parity = i_cmd.line_status[LS_PE_BIT];
    assign evt.frame  = i_cmd.line_status[LS_FE_BIT];
    assign evt.brk    = i_cmd.line_status[LS_BI_BIT];

    urxf_ring #(
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (ring_cmd),
        .i_entry    (wr_entry),
        .o_stat     (ring_stat),
        .o_rd_entry (rd_entry),
        .o_count    (count)
    );

    urxf_counters u_counters (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_evt    (evt),
        .o_totals (totals)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_pop_valid <= 1'b0;
            r_dropped   <= 1'b0;
            r_discarded <= 1'b0;
        end else begin
            r_valid     <= accept;
            r_pop_valid <= ring_cmd.pop;
            r_dropped   <= evt.drop;
            r_discarded <= disc;
        end
    end

    assign count_ext = {{FILL_W{1'b0}}, count};

    assign o_result_valid            = r_valid;
    assign o_result.pop_byte         = r_pop_valid ? rd_entry.data : 8'd0;
    assign o_result.pop_flags        = r_pop_valid ? rd_entry.flags : 3'd0;
    assign o_result.pop_valid        = r_pop_valid;
    assign o_result.fill_count       = count_ext[FILL_W-1:0];
    assign o_result.dropped_oldest   = r_dropped;
    assign o_result.discarded        = r_discarded;
    assign o_result.overrun_total    = totals.overrun;
    assign o_result.parity_total     = totals.parity;
    assign o_result.break_total      = totals.brk;
    assign o_result.frame_total      = totals.frame;
    assign o_result.received_total   = totals.received;

`ifndef SYNTH
    a_result_follows_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_rst_n) |=> o_result_valid)
        else $error("transfer produced no result strobe");
    a_strobe_needs_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!accept && i_rst_n) |=> !o_result_valid)
        else $error("result strobe without a transfer");
`endif

endmodule

[src/urxf_ring.sv]
// Ring storage: entry memory, read/write indices and fill count.
// Depends on urxf_pkg.
module urxf_ring #(
    parameter int DEPTH = urxf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  urxf_pkg::t_ring_cmd       i_cmd,
    input  urxf_pkg::t_entry          i_entry,
    output urxf_pkg::t_ring_stat      o_stat,
    output urxf_pkg::t_entry          o_rd_entry,
    output logic [$clog2(DEPTH)-1:0]  o_count
);
    import urxf_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

    t_entry        r_mem [DEPTH];
    t_entry        r_rd_entry;
    logic [IW-1:0] r_wr_idx, n_wr_idx;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic [IW-1:0] r_count, n_count;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == LAST);
    assign o_rd_entry   = r_rd_entry;
    assign o_count      = r_count;

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_count  = r_count;
        if (i_cmd.push) begin
            n_wr_idx = (r_wr_idx == LAST) ? '0 : r_wr_idx + 1'b1;
            if (o_stat.full) begin
                n_rd_idx = (r_rd_idx == LAST) ? '0 : r_rd_idx + 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else if (i_cmd.pop) begin
            n_rd_idx = (r_rd_idx == LAST) ? '0 : r_rd_idx + 1'b1;
            n_count  = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx <= '0;
            r_rd_idx <= '0;
            r_count  <= '0;
        end else begin
            r_wr_idx <= n_wr_idx;
            r_rd_idx <= n_rd_idx;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_wr_idx] <= i_entry;
        end
        r_rd_entry <= r_mem[r_rd_idx];
    end

`ifndef SYNTH
    a_full_push_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.push && o_stat.full) |=> $stable(r_count))
        else $error("fill count moved on overrun push");
    a_empty_indices_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> (r_wr_idx == r_rd_idx))
        else $error("empty ring with unequal indices");
    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pop |-> !o_stat.empty)
        else $error("pop issued on empty ring");
`endif

endmodule

[src/urxf_counters.sv]
// Wrapping event counters for overrun, parity, framing, break and queued bytes.
// Depends on urxf_pkg.
module urxf_counters (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  urxf_pkg::t_stat_evt  i_evt,
    output urxf_pkg::t_totals    o_totals
);
    import urxf_pkg::*;

    t_totals r_totals;

    assign o_totals = r_totals;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_totals <= '0;
        end else if (i_evt.push) begin
            r_totals.received <= r_totals.received + 1'b1;
            if (i_evt.drop) begin
                r_totals.overrun <= r_totals.overrun + 1'b1;
            end
            if (i_evt.parity) begin
                r_totals.parity <= r_totals.parity + 1'b1;
            end
            if (i_evt.frame) begin
                r_totals.frame <= r_totals.frame + 1'b1;
            end
            if (i_evt.brk) begin
                r_totals.brk <= r_totals.brk + 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_drop_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.drop |-> i_evt.push)
        else $error("overrun flagged without a queued byte");
`endif

endmodule

[verif/urxf_checker.sv]
// Checker for the UART receive ring: watches command, result and register transfers,
// predicts each result and compares it field by field. Depends on urxf_pkg.
module urxf_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  urxf_pkg::t_cmd                i_cmd,
    input  logic                          i_result_valid,
    input  urxf_pkg::t_result             i_result,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic                          i_pready,
    input  logic [urxf_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [urxf_pkg::PDATA_W-1:0]  i_pwdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import urxf_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam logic [PADDR_W-1:0] IGNORE_BREAK_ADDR = PADDR_W'(4 * int'(REG_IGNORE_BREAK));

    t_entry      ring [DEPTH];
    int unsigned wr_slot;
    int unsigned rd_slot;
    logic        ignore_brk;
    t_totals     tally;
    t_result     expected_results [$];
    t_result     want;
    int          fails = 0;
    int          outstanding = 0;

    assign o_fail_count = fails;
    assign o_pending    = outstanding;

    function automatic int unsigned occupancy();
        return (wr_slot + DEPTH - rd_slot) % DEPTH;
    endfunction

    function automatic int unsigned next_slot(int unsigned s);
        return (s + 1 == DEPTH) ? 0 : s + 1;
    endfunction

    function automatic t_result predict_rx(t_cmd c);
        t_result r;
        t_entry  e;
        r = '0;
        if (c.opcode == OP_POP) begin
            if (occupancy() != 0) begin
                r.pop_byte  = ring[rd_slot].data;
                r.pop_flags = ring[rd_slot].flags;
                r.pop_valid = 1'b1;
                rd_slot     = next_slot(rd_slot);
            end
        end else if (c.line_status[LS_DR_BIT]) begin
            if (ignore_brk && c.line_status[LS_BI_BIT]) begin
                r.discarded = 1'b1;
            end else begin
                if (occupancy() >= DEPTH - 1) begin
                    rd_slot          = next_slot(rd_slot);
                    tally.overrun    = tally.overrun + 1;
                    r.dropped_oldest = 1'b1;
                end
                e.data  = c.rx_byte;
                e.flags = {c.line_status[LS_BI_BIT], c.line_status[LS_FE_BIT],
                           c.line_status[LS_PE_BIT]};
                if (c.line_status[LS_PE_BIT]) tally.parity = tally.parity + 1;
                if (c.line_status[LS_FE_BIT]) tally.frame = tally.frame + 1;
                if (c.line_status[LS_BI_BIT]) tally.brk = tally.brk + 1;
                ring[wr_slot]  = e;
                wr_slot        = next_slot(wr_slot);
                tally.received = tally.received + 1;
            end
        end
        r.fill_count     = FILL_W'(occupancy());
        r.overrun_total  = tally.overrun;
        r.parity_total   = tally.parity;
        r.break_total    = tally.brk;
        r.frame_total    = tally.frame;
        r.received_total = tally.received;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
        if (got_val !== exp_val) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, got_val);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wr_slot    = 0;
            rd_slot    = 0;
            ignore_brk = 1'b0;
            tally      = '0;
            expected_results.delete();
        end else begin
            if (i_result_valid) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("pop_byte", 32'(want.pop_byte), 32'(i_result.pop_byte));
                    check_field("pop_flags", 32'(want.pop_flags), 32'(i_result.pop_flags));
                    check_field("pop_valid", 32'(want.pop_valid), 32'(i_result.pop_valid));
                    check_field("fill_count", 32'(want.fill_count),
                                32'(i_result.fill_count));
                    check_field("dropped_oldest", 32'(want.dropped_oldest),
                                32'(i_result.dropped_oldest));
                    check_field("discarded", 32'(want.discarded), 32'(i_result.discarded));
                    check_field("overrun_total", want.overrun_total, i_result.overrun_total);
                    check_field("parity_total", want.parity_total, i_result.parity_total);
                    check_field("break_total", want.break_total, i_result.break_total);
                    check_field("frame_total", want.frame_total, i_result.frame_total);
                    check_field("received_total", want.received_total,
                                i_result.received_total);
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(predict_rx(i_cmd));
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == IGNORE_BREAK_ADDR)
                ignore_brk = i_pwdata[0];
        end
        outstanding = expected_results.size();
    end

endmodule

[verif/uart_rx_fifo_error_tagging_unit_test.sv]
// Testbench top for the UART receive ring: drives directed and random command transfers
// and register writes, and gives the verdict. Depends on urxf_pkg, urxf_checker and the block.
module uart_rx_fifo_error_tagging_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import urxf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int FILL_NET    = 1040;
    localparam logic [7:0] LSR_DR = 8'(1) << LS_DR_BIT;
    localparam logic [7:0] LSR_PE = 8'(1) << LS_PE_BIT;
    localparam logic [7:0] LSR_FE = 8'(1) << LS_FE_BIT;
    localparam logic [7:0] LSR_BI = 8'(1) << LS_BI_BIT;
    localparam logic [PADDR_W-1:0] IGNORE_BREAK_ADDR = PADDR_W'(4 * int'(REG_IGNORE_BREAK));
    localparam logic [PDATA_W-1:0] BREAK_KEEP = '0;
    localparam logic [PDATA_W-1:0] BREAK_DROP = PDATA_W'(1);

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    t_cmd                i_cmd = '0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic                busy;
    logic                o_result_valid;
    t_result             o_result;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    int                  fail_count;
    int                  pending;
    int                  cycle_count = 0;
    int                  burst_left = 0;

    uart_rx_fifo_error_tagging_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    urxf_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_cmd          (i_cmd),
        .i_result_valid (o_result_valid),
        .i_result       (o_result),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic t_cmd cmd_of(logic op, logic [7:0] ls, logic [7:0] data);
        t_cmd c;
        c.opcode      = op;
        c.line_status = ls;
        c.rx_byte     = data;
        return c;
    endfunction

    function automatic t_cmd rand_cmd(int unsigned push_pct, int unsigned pop_pct);
        t_cmd        c;
        int unsigned roll;
        roll          = $urandom_range(0, 99);
        c.rx_byte     = 8'($urandom);
        c.line_status = 8'($urandom);
        if (roll < pop_pct) begin
            c.opcode = OP_POP;
        end else begin
            c.opcode                 = OP_BYTE;
            c.line_status[LS_DR_BIT] = (roll < pop_pct + push_pct);
        end
        return c;
    endfunction

    task automatic issue(t_cmd c);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic drain();
        start <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (pending != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_mix(int n, int unsigned push_pct, int unsigned pop_pct);
        repeat (n) issue(rand_cmd(push_pct, pop_pct));
    endtask

    initial begin
        t_cmd c;
        int   net;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        issue(cmd_of(OP_POP, 8'h00, 8'h00));
        issue(cmd_of(OP_BYTE, 8'h00, 8'h00));
        issue(cmd_of(OP_BYTE, 8'hFE, 8'hFF));
        issue(cmd_of(OP_BYTE, LSR_DR, 8'h00));
        issue(cmd_of(OP_BYTE, LSR_DR, 8'hFF));
        issue(cmd_of(OP_BYTE, LSR_DR | LSR_PE, 8'h55));
        issue(cmd_of(OP_BYTE, LSR_DR | LSR_FE, 8'hAA));
        issue(cmd_of(OP_BYTE, LSR_DR | LSR_BI, 8'h01));
        issue(cmd_of(OP_BYTE, 8'hFF, 8'h80));
        issue(cmd_of(OP_POP, 8'hFF, 8'hFF));
        repeat (5) issue(cmd_of(OP_POP, 8'h00, 8'h00));
        drain();
        apb_write(IGNORE_BREAK_ADDR, BREAK_DROP);
        issue(cmd_of(OP_BYTE, LSR_DR | LSR_BI, 8'h12));
        issue(cmd_of(OP_BYTE, 8'hFF, 8'hFF));
        issue(cmd_of(OP_BYTE, LSR_DR | LSR_PE | LSR_FE, 8'h34));
        issue(cmd_of(OP_BYTE, LSR_BI, 8'h56));
        issue(cmd_of(OP_POP, 8'h00, 8'h00));
        issue(cmd_of(OP_POP, 8'h00, 8'h00));

        run_mix(40, 50, 40);
        drain();
        apb_write(IGNORE_BREAK_ADDR, BREAK_KEEP);

        // fill past capacity so the oldest entries get overrun
        net = 0;
        while (net < FILL_NET) begin
            c = rand_cmd(97, 1);
            issue(c);
            if (c.opcode == OP_POP)
                net--;
            else if (c.line_status[LS_DR_BIT])
                net++;
        end
        drain();
        apb_write(IGNORE_BREAK_ADDR, BREAK_DROP);
        run_mix(120, 30, 60);
        drain();

        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[uart_rx_fifo_error_tagging_unit.f]
src/urxf_pkg.sv
src/urxf_ring.sv
src/urxf_counters.sv
src/uart_rx_fifo_error_tagging_unit.sv
verif/urxf_checker.sv
verif/uart_rx_fifo_error_tagging_unit_test.sv
